// ----- hdl/fppw_pkg.sv -----
// Package for the framed packet to pulse width parser.
// Holds the shared types, codes and constants; depends on nothing.
package fppw_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 8;
  localparam int unsigned CHANNELS_DEF    = 5;

  localparam int unsigned NUM_PULSES  = 5;
  localparam int unsigned LIGHT_IDX   = 5;
  localparam int unsigned LOCK_IDX    = 6;
  localparam int unsigned SNAP_BYTES  = 7;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned PULSE_W    = 12;
  localparam int unsigned LIMIT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [7:0]         HEADER_RESET = 8'h55;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 5'd20;

  // Width for a signed byte s: 1500 + 5*s, with s = b - 256 for b >= 128.
  localparam logic [PULSE_W-1:0] PULSE_BASE     = 12'd1500;
  localparam logic [PULSE_W-1:0] PULSE_SIGN_ADJ = 12'd1280;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEADER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT  = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_DATA   = 2'd2,
    PH_CHECK  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_GOOD = 2'd1,
    ST_FAIL = 2'd2
  } status_t;

  // One classified item on its way from the parser to the output stage.
  typedef struct packed {
    status_t                    status;
    logic [SNAP_BYTES-1:0][7:0] snap;
  } fppw_entry_t;

endpackage

// ----- hdl/fppw_byte_if.sv -----
// Input channel carrying one received byte per item.
// Depends on nothing.
interface fppw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

// ----- hdl/fppw_result_if.sv -----
// Result channel carrying status and the held thruster values.
// Depends on nothing.
interface fppw_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] pulse_left_alt;
  logic [11:0] pulse_right_alt;
  logic [11:0] pulse_left_heading;
  logic [11:0] pulse_right_heading;
  logic [11:0] pulse_back_alt;
  logic [7:0]  light_code;
  logic        lock_flag;

  modport source (output valid, output status, output pulse_left_alt,
                  output pulse_right_alt, output pulse_left_heading,
                  output pulse_right_heading, output pulse_back_alt,
                  output light_code, output lock_flag, input ready);
  modport sink   (input valid, input status, input pulse_left_alt,
                  input pulse_right_alt, input pulse_left_heading,
                  input pulse_right_heading, input pulse_back_alt,
                  input light_code, input lock_flag, output ready);
endinterface

// ----- hdl/framed_packet_to_pulse_widths.sv -----
// Framed packet to pulse width parser, top level.
// Path: the item of an accepted byte goes into the queue and then into the
// output register, when nothing is waiting ahead of it in the queue.
// Throughput: one byte per cycle while the queue has room; the parser
// updates on every accepted byte, and a two-item queue lets parser and
// output stage stall separately. Reset: synchronous, active low; all
// registers but the queue storage return to defaults. Depends on fppw_pkg,
// fppw_byte_if, fppw_result_if, fppw_front, fppw_queue and fppw_back.
module framed_packet_to_pulse_widths
  import fppw_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int unsigned CHANNELS    = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  fppw_byte_if.sink             in_if,
  fppw_result_if.source         out_if
);

  // Every accepted byte produces exactly one item. The parser classifies it
  // in the cycle it arrives and hands a status plus a snapshot of the first
  // payload bytes to the queue; the output stage turns good frames into
  // pulse widths and holds them, the light code and the lock flag until the next good frame.
  logic        push_valid, push_ready;
  fppw_entry_t push_data;
  logic        pop_valid, pop_ready;
  fppw_entry_t pop_data;

  fppw_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_if      (in_if),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // The queue decouples the parser from output back-pressure.
  fppw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  fppw_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_if    (out_if)
  );

endmodule

// ----- hdl/fppw_front.sv -----
// Frame parser: accepts bytes, tracks the frame and classifies each item.
// Depends on fppw_pkg and fppw_byte_if.
module fppw_front
  import fppw_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  fppw_byte_if.sink             in_if,
  output logic                  push_valid,
  input  logic                  push_ready,
  output fppw_entry_t           push_data
);

  localparam int unsigned LW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned IW = $clog2(MAX_PAYLOAD);

  logic [7:0]         header_r;
  logic [LIMIT_W-1:0] limit_r;

  phase_t                      phase_r, phase_nxt;
  logic [LW-1:0]               flen_r, flen_nxt;
  logic [LW-1:0]               cnt_r, cnt_nxt;
  logic [7:0]                  xor_r, xor_nxt;
  logic [LIMIT_W-1:0]          bsf_r, bsf_nxt;
  logic [MAX_PAYLOAD-1:0][7:0] store_r, store_nxt;

  logic [7:0]  b;
  logic        acc;
  logic        bad_len;
  logic        frame_end;
  logic        abort;
  logic [LW:0] cnt_inc;
  status_t     status;

  assign b          = in_if.byte_in;
  assign in_if.ready = push_ready;
  assign push_valid = in_if.valid;
  assign acc        = in_if.valid && push_ready;

  assign bad_len   = (b == 8'd0) || (b > 8'(MAX_PAYLOAD));
  assign cnt_inc   = {1'b0, cnt_r} + {{LW{1'b0}}, 1'b1};
  assign frame_end = (phase_r == PH_CHECK) || ((phase_r == PH_LENGTH) && bad_len);
  assign abort     = !frame_end && (bsf_r >= limit_r);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEADER: begin
        if (b == header_r) phase_nxt = PH_LENGTH;
      end
      PH_LENGTH: begin
        phase_nxt = bad_len ? PH_HEADER : PH_DATA;
      end
      PH_DATA: begin
        if (cnt_inc >= {1'b0, flen_r}) phase_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        phase_nxt = PH_HEADER;
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
    if (abort) phase_nxt = PH_HEADER;
  end

  // Counters, payload capture and classification.
  always_comb begin
    flen_nxt  = flen_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    bsf_nxt   = bsf_r;
    store_nxt = store_r;
    status    = ST_BUSY;
    case (phase_r)
      PH_HEADER: begin
      end
      PH_LENGTH: begin
        if (bad_len) begin
          status = ST_FAIL;
        end else begin
          flen_nxt = b[LW-1:0];
        end
      end
      PH_DATA: begin
        if (cnt_r < LW'(MAX_PAYLOAD)) store_nxt[cnt_r[IW-1:0]] = b;
        if (cnt_inc < {1'b0, flen_r}) xor_nxt = xor_r ^ b;
        cnt_nxt = cnt_inc[LW-1:0];
      end
      PH_CHECK: begin
        status = (xor_r == b) ? ST_GOOD : ST_FAIL;
      end
      default: begin
      end
    endcase
    if (frame_end || abort) begin
      cnt_nxt = '0;
      xor_nxt = '0;
      bsf_nxt = '0;
    end else begin
      bsf_nxt = bsf_r + LIMIT_W'(1);
    end
    if (abort) status = ST_FAIL;
  end

  always_comb begin
    push_data.status = status;
    for (int i = 0; i < SNAP_BYTES; i++) begin
      push_data.snap[i] = store_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
      limit_r  <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_HEADER: header_r <= cfg_wdata;
        CFG_IDX_LIMIT:  limit_r  <= cfg_wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      flen_r  <= '0;
      cnt_r   <= '0;
      xor_r   <= '0;
      bsf_r   <= '0;
      store_r <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      flen_r  <= flen_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
      bsf_r   <= bsf_nxt;
      store_r <= store_nxt;
    end
  end

  a_check_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == PH_CHECK) |=> (phase_r == PH_HEADER && bsf_r == '0 && cnt_r == '0))
    else $error("check byte did not return the parser to header wait");

  a_limit_aborts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r != PH_CHECK && bsf_r >= limit_r) |-> (push_data.status == ST_FAIL))
    else $error("byte limit reached without an abort");

  a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (cnt_r < flen_r))
    else $error("payload count ran past the frame length");

endmodule

// ----- hdl/fppw_queue.sv -----
// Short item queue between the parser and the output stage.
// Depends on fppw_pkg.
module fppw_queue
  import fppw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  fppw_entry_t push_data,
  output logic        pop_valid,
  input  logic        pop_ready,
  output fppw_entry_t pop_data
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  fppw_entry_t mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push, pop;

  assign push_ready = (count_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond its depth");

  a_push_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && pop) |=> $stable(count_r))
    else $error("simultaneous push and pop changed the count");

  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CW'(QUEUE_DEPTH)) |-> !push)
    else $error("item pushed into a full queue");

endmodule

// ----- hdl/fppw_back.sv -----
// Output stage: latches pulse widths on good frames and holds the result.
// Depends on fppw_pkg and fppw_result_if.
module fppw_back
  import fppw_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  fppw_entry_t   pop_data,
  fppw_result_if.source out_if
);

  logic                             out_valid_r;
  status_t                          status_r;
  logic [NUM_PULSES-1:0][PULSE_W-1:0] pulse_r, pulse_nxt;
  logic [7:0]                       light_r;
  logic                             lock_r;
  logic                             pop;

  assign pop_ready = !out_valid_r || out_if.ready;
  assign pop       = pop_valid && pop_ready;

  // 5*b as a shift and add, less 1280 when the byte is negative.
  always_comb begin
    for (int i = 0; i < NUM_PULSES; i++) begin
      if (i < CHANNELS) begin
        pulse_nxt[i] = PULSE_BASE + {2'b00, pop_data.snap[i], 2'b00}
                     + {4'b0000, pop_data.snap[i]}
                     - (pop_data.snap[i][7] ? PULSE_SIGN_ADJ : '0);
      end else begin
        pulse_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      status_r    <= ST_BUSY;
      pulse_r     <= '0;
      light_r     <= '0;
      lock_r      <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
      status_r    <= pop_data.status;
      if (pop_data.status == ST_GOOD) begin
        pulse_r <= pulse_nxt;
        light_r <= pop_data.snap[LIGHT_IDX];
        lock_r  <= (pop_data.snap[LOCK_IDX] != 8'd0);
      end
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid               = out_valid_r;
  assign out_if.status              = status_r;
  assign out_if.pulse_left_alt      = pulse_r[0];
  assign out_if.pulse_right_alt     = pulse_r[1];
  assign out_if.pulse_left_heading  = pulse_r[2];
  assign out_if.pulse_right_heading = pulse_r[3];
  assign out_if.pulse_back_alt      = pulse_r[4];
  assign out_if.light_code          = light_r;
  assign out_if.lock_flag           = lock_r;

  a_good_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pop_data.status == ST_GOOD) |=> (out_valid_r && status_r == ST_GOOD))
    else $error("good frame did not reach the output register");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=>
      (out_valid_r && $stable(status_r) && $stable(pulse_r)))
    else $error("result item changed while waiting for the receiver");

  a_fail_keeps_pulses: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pop_data.status != ST_GOOD) |=> $stable(pulse_r))
    else $error("pulse widths changed without a good frame");

endmodule

// ----- tb/sv/framed_packet_to_pulse_widths_tb.sv -----
// Self-checking testbench for the framed packet to pulse width parser.
// Holds its own frame parser predictor, directed and random stimulus and the
// result checker; depends on fppw_pkg, fppw_byte_if, fppw_result_if and the RTL.
`timescale 1ns / 100ps

module framed_packet_to_pulse_widths_tb;
  import fppw_pkg::*;

  localparam int unsigned MAX_PL = MAX_PAYLOAD_DEF;
  localparam int unsigned PAY_IW = $clog2(MAX_PL);

  // One expected result item: the status of the byte and the held outputs.
  typedef struct packed {
    status_t                            status;
    logic [NUM_PULSES-1:0][PULSE_W-1:0] widths;
    logic [7:0]                         light;
    logic                               lock;
  } thruster_view_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fppw_byte_if   byte_ch ();
  fppw_result_if result_ch ();

  framed_packet_to_pulse_widths u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (byte_ch),
    .out_if    (result_ch)
  );

  // The clock runs at 50 MHz: 10 ns low, then 10 ns high.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predictor state. The register copies follow every write that the
  // testbench makes; the parser state mirrors the block after reset.
  logic [7:0]         hdr_cfg = HEADER_RESET;
  logic [LIMIT_W-1:0] lim_cfg = LIMIT_RESET;

  phase_t             ph      = PH_HEADER;
  logic [3:0]         flen    = '0;
  logic [3:0]         pcount  = '0;
  logic [7:0]         xacc    = '0;
  logic [4:0]         since   = '0;
  logic [7:0]         pay [MAX_PL]         = '{default: '0};
  logic [PULSE_W-1:0] held_w [NUM_PULSES] = '{default: '0};
  logic [7:0]         held_lt = '0;
  logic               held_lk = 1'b0;

  // Expected result items, oldest first.
  thruster_view_t due_views [$];

  int mismatches = 0;
  int bytes_sent = 0;

  // Idling switches. The sender leaves gaps and the receiver withholds ready
  // only while these are set; the final traffic phase clears both.
  bit sender_gaps = 1'b1;
  bit sink_stalls = 1'b1;

  // A frame ends or is abandoned: the parser waits for a header again and
  // the payload position, running XOR and byte counter start afresh.
  function automatic void drop_frame();
    ph     = PH_HEADER;
    pcount = '0;
    xacc   = '0;
    since  = '0;
  endfunction

  // Advances the predictor by one received byte and returns the result item
  // that the block should produce for it.
  function automatic thruster_view_t parse_byte(input logic [7:0] b);
    thruster_view_t view;
    status_t        st;
    bit             ended;
    int             c;
    st    = ST_BUSY;
    ended = 1'b0;
    case (ph)
      PH_HEADER: begin
        if (b == hdr_cfg) ph = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (b == 8'h00 || b > MAX_PL) begin
          drop_frame();
          st    = ST_FAIL;
          ended = 1'b1;
        end else begin
          flen = b[3:0];
          ph   = PH_DATA;
        end
      end
      PH_DATA: begin
        if (pcount < MAX_PL) pay[pcount[PAY_IW-1:0]] = b;
        // The last payload byte is stored but left out of the check.
        if (pcount + 1 < flen) xacc ^= b;
        if (pcount + 1 >= flen) ph = PH_CHECK;
        pcount = pcount + 4'd1;
      end
      default: begin
        if (xacc == b) begin
          // Width is 1500 us plus 5 us per step of the signed payload byte.
          for (c = 0; c < NUM_PULSES; c++) begin
            held_w[c] = (c < CHANNELS_DEF) ?
                        PULSE_W'(1500 + 5 * int'($signed(pay[c]))) : '0;
          end
          held_lt = pay[LIGHT_IDX];
          held_lk = (pay[LOCK_IDX] != 8'h00);
          st      = ST_GOOD;
        end else begin
          st = ST_FAIL;
        end
        drop_frame();
        ended = 1'b1;
      end
    endcase
    // Any byte that does not close a frame counts towards the limit, and
    // an overrun wins over whatever the byte itself did.
    if (!ended) begin
      if (since >= lim_cfg) begin
        drop_frame();
        st = ST_FAIL;
      end else begin
        since = since + 5'd1;
      end
    end
    view.status = st;
    for (c = 0; c < NUM_PULSES; c++) view.widths[c] = held_w[c];
    view.light = held_lt;
    view.lock  = held_lk;
    return view;
  endfunction

  // Random byte that favours the sign boundaries and the extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one byte and returns at the edge where it is accepted, with
  // valid left high so that a following item can go out without a gap.
  task automatic send_byte(input logic [7:0] value);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.byte_in <= value;
    do @(posedge clk); while (!byte_ch.ready);
    due_views.push_back(parse_byte(value));
    bytes_sent++;
  endtask

  // Sends a frame with the current header. Only the first keep payload bytes
  // go out; the check byte follows only when the payload is complete, and a
  // nonzero spoil corrupts it.
  task automatic send_frame(input logic [7:0] body [MAX_PL], input int len,
                            input int keep, input logic [7:0] spoil);
    logic [7:0] check;
    int         i;
    check = 8'h00;
    for (i = 0; i < len - 1; i++) check ^= body[i];
    send_byte(hdr_cfg);
    send_byte(8'(len));
    for (i = 0; i < len && i < keep; i++) send_byte(body[i]);
    if (keep >= len) send_byte(check ^ spoil);
  endtask

  // Registers change only while the block is quiet: the sender stops, every
  // expected item is collected and the pipeline is given time to empty.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    byte_ch.valid <= 1'b0;
    while (due_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_HEADER) hdr_cfg = value;
    else lim_cfg = value[LIMIT_W-1:0];
  endtask

  // Bytes that are not a header are ignored apart from the byte counter.
  task automatic test_idle_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // A full-length frame across the signed range: 0x80 gives the narrowest
  // width, 0x7F the widest, and a nonzero lock byte sets the lock.
  task automatic test_good_frame();
    logic [7:0] body [MAX_PL];
    body = '{8'h80, 8'h7F, 8'h00, 8'hFF, 8'h01, 8'hA5, 8'h3C, 8'h5A};
    send_frame(body, 8, 8, 8'h00);
  endtask

  // Length bytes of zero and of one more than the payload store are refused.
  task automatic test_bad_length();
    send_byte(hdr_cfg);
    send_byte(8'h00);
    send_byte(hdr_cfg);
    send_byte(8'(MAX_PL + 1));
  endtask

  // A one-byte frame checks against an empty XOR, so a check byte of one
  // fails and nothing is latched, although the payload byte is stored.
  task automatic test_check_failure();
    logic [7:0] body [MAX_PL];
    body = '{8'hC3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(body, 1, 1, 8'h01);
  endtask

  // A two-byte frame latches the light and lock bytes left over from the
  // long frame earlier on.
  task automatic test_short_frame();
    logic [7:0] body [MAX_PL];
    body = '{8'h7F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(body, 2, 2, 8'h00);
  endtask

  // With a limit of one the length byte already overruns the counter.
  task automatic test_byte_limit();
    write_register(CFG_IDX_LIMIT, 8'd1);
    send_byte(hdr_cfg);
    send_byte(8'h08);
    write_register(CFG_IDX_LIMIT, 8'(LIMIT_RESET));
  endtask

  // One stretch of random traffic under a fixed header and byte limit. It
  // opens with enough stray bytes to overrun the limit, then sends mostly
  // well-formed frames, with some corrupt, truncated or refused ones and
  // bursts of stray bytes in between.
  task automatic run_traffic_phase(input logic [7:0] hdr, input logic [4:0] lim,
                                   input int budget, input bit calm);
    logic [7:0] body [MAX_PL];
    int         stop;
    int         len;
    int         kind;
    int         i;
    write_register(CFG_IDX_HEADER, hdr);
    write_register(CFG_IDX_LIMIT, {3'b000, lim});
    sender_gaps = !calm;
    sink_stalls = !calm;
    repeat (int'(lim) + 2) send_byte(hdr ^ 8'($urandom_range(1, 255)));
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      sender_gaps = !calm && $urandom_range(0, 3) != 0;
      sink_stalls = !calm && $urandom_range(0, 3) != 0;
      kind = $urandom_range(0, 19);
      if (kind >= 17) begin
        repeat ($urandom_range(1, 6)) send_byte(pick_byte());
      end else if (kind == 16) begin
        send_byte(hdr);
        send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(MAX_PL + 1, 255)));
      end else begin
        len = $urandom_range(1, MAX_PL);
        for (i = 0; i < MAX_PL; i++) body[i] = pick_byte();
        if ($urandom_range(0, 1)) body[LOCK_IDX] = 8'h00;
        send_frame(body, len,
                   (kind == 15) ? $urandom_range(0, len - 1) : len,
                   (kind == 14) ? 8'($urandom_range(1, 255)) : 8'h00);
      end
    end
  endtask

  // The header extremes, the largest limit and a limit of one appear among the
  // settings; the last phase runs with no idling on either side.
  task automatic test_random_traffic();
    run_traffic_phase(HEADER_RESET, LIMIT_RESET, 350, 1'b0);
    run_traffic_phase(8'h00, 5'd31, 350, 1'b0);
    run_traffic_phase(8'hFF, 5'd1, 100, 1'b0);
    run_traffic_phase(8'($urandom_range(0, 255)), 5'($urandom_range(1, 31)), 350, 1'b0);
    run_traffic_phase(8'($urandom_range(0, 255)), 5'($urandom_range(10, 31)), 350, 1'b1);
  endtask

  // Reports a wrong field in full for the first few cases, then only counts.
  task automatic flag_field(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
  endtask

  // The receiver takes items at random, withholding ready in bursts.
  initial begin
    result_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Each accepted result item is compared field by field with the oldest
  // expectation. Both sides are sampled as they stood before the edge.
  always @(posedge clk) begin
    thruster_view_t                     want;
    logic [NUM_PULSES-1:0][PULSE_W-1:0] seen;
    int                                 c;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (due_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result item with nothing expected at %0t", $realtime);
      end else begin
        want    = due_views.pop_front();
        seen[0] = result_ch.pulse_left_alt;
        seen[1] = result_ch.pulse_right_alt;
        seen[2] = result_ch.pulse_left_heading;
        seen[3] = result_ch.pulse_right_heading;
        seen[4] = result_ch.pulse_back_alt;
        if (result_ch.status !== want.status)
          flag_field("status", want.status, result_ch.status);
        for (c = 0; c < NUM_PULSES; c++) begin
          if (seen[c] !== want.widths[c])
            flag_field($sformatf("pulse width %0d", c), want.widths[c], seen[c]);
        end
        if (result_ch.light_code !== want.light)
          flag_field("light code", want.light, result_ch.light_code);
        if (result_ch.lock_flag !== want.lock)
          flag_field("lock flag", want.lock, result_ch.lock_flag);
      end
    end
  end

  // Main sequence: reset, the directed cases in turn, random traffic, then
  // the drain and the verdict.
  initial begin
    int spin;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_IDX_HEADER;
    cfg_wdata       <= '0;
    byte_ch.valid   <= 1'b0;
    byte_ch.byte_in <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_bytes();
    test_good_frame();
    test_bad_length();
    test_check_failure();
    test_short_frame();
    test_byte_limit();
    test_random_traffic();

    byte_ch.valid <= 1'b0;
    for (spin = 0; spin < 5000 && due_views.size() != 0; spin++) @(posedge clk);
    if (due_views.size() != 0) begin
      mismatches += due_views.size();
      $display("%0d expected result items never arrived", due_views.size());
    end
    // A result trails its byte through the queue and the output register; the extra wait catches stray items.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: the timeout is many times the slowest correct run.
  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/fppw_pkg.sv
hdl/fppw_byte_if.sv
hdl/fppw_result_if.sv
hdl/fppw_front.sv
hdl/fppw_queue.sv
hdl/fppw_back.sv
hdl/framed_packet_to_pulse_widths.sv
tb/sv/framed_packet_to_pulse_widths_tb.sv
